// File: hw/rtl/ddssp_pkg.sv
`default_nettype none

package ddssp_pkg;

    // Width of the pulse length register and of the per-channel pulse counters.
    localparam int PULSE_CNT_BITS = 8;

    typedef logic [PULSE_CNT_BITS-1:0] t_pulse_cnt;

    localparam t_pulse_cnt PULSE_WIDTH_RESET = t_pulse_cnt'(2);
    localparam t_pulse_cnt PULSE_WIDTH_MIN   = t_pulse_cnt'(1);

    // Channel slots in the per-channel arrays.
    localparam int CH_LEFT  = 0;
    localparam int CH_RIGHT = 1;
    localparam int NUM_CH   = 2;

endpackage

`default_nettype wire

// File: hw/rtl/ddssp_ifs.sv
`default_nettype none

interface ddssp_in_if #(
    parameter int PHASE_BITS = 24
);
    logic                valid;
    logic                ready;
    logic [PHASE_BITS:0] left_increment;
    logic [PHASE_BITS:0] right_increment;
    logic                left_direction;
    logic                right_direction;

    modport source (
        output valid, left_increment, right_increment, left_direction, right_direction,
        input  ready
    );
    modport sink (
        input  valid, left_increment, right_increment, left_direction, right_direction,
        output ready
    );
endinterface

interface ddssp_res_if;
    logic valid;
    logic ready;
    logic left_step_level;
    logic right_step_level;
    logic left_pulse_started;
    logic right_pulse_started;
    logic left_direction_out;
    logic right_direction_out;

    modport source (
        output valid, left_step_level, right_step_level, left_pulse_started,
               right_pulse_started, left_direction_out, right_direction_out,
        input  ready
    );
    modport sink (
        input  valid, left_step_level, right_step_level, left_pulse_started,
               right_pulse_started, left_direction_out, right_direction_out,
        output ready
    );
endinterface

interface ddssp_cfg_if;
    logic                  valid;
    logic                  ready;
    ddssp_pkg::t_pulse_cnt data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dual_dds_step_pulse_generator.sv
// Channel   Dir  Handshake      Item contents
// i_in      in   valid/ready    left/right phase increment, left/right direction
// o_res     out  valid/ready    step levels, pulse-start flags, directions
// i_cfg     in   valid/ready    pulse width in ticks (ready is always high)
//
// One item is taken every cycle unless o_res stalls; an accepted item goes
// into the input register, then through the phase add and compare into the
// result register. Throughput is one item per cycle while o_res.ready stays high.
// When o_res is stalled the result register holds, the input register fills,
// and then i_in.ready drops. Reset clears both phases, both pulse counters,
// the pipeline valid bits and sets the pulse width to two ticks.

`default_nettype none

module dual_dds_step_pulse_generator #(
    parameter int PHASE_BITS = 24
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ddssp_in_if.sink    i_in,
    ddssp_res_if.source o_res,
    ddssp_cfg_if.sink   i_cfg
);
    import ddssp_pkg::*;

    localparam int INC_BITS = PHASE_BITS + 1;
    localparam logic [INC_BITS-1:0] PHASE_ONE = INC_BITS'(1) << PHASE_BITS;

    // Configuration.
    t_pulse_cnt r_pulse_width;
    t_pulse_cnt width_eff;

    // Input register.
    logic                r_in_valid;
    logic [INC_BITS-1:0] r_inc [NUM_CH];
    logic                r_dir [NUM_CH];

    // Channel state.
    logic [PHASE_BITS-1:0] r_phase [NUM_CH];
    t_pulse_cnt            r_rem   [NUM_CH];

    // Result register.
    logic r_out_valid;
    logic r_level   [NUM_CH];
    logic r_started [NUM_CH];
    logic r_dir_out [NUM_CH];

    // Next values of the channel state.
    logic [PHASE_BITS-1:0] n_phase [NUM_CH];
    t_pulse_cnt            n_rem   [NUM_CH];
    logic                  n_wrap  [NUM_CH];

    logic [INC_BITS-1:0] inc_sat [NUM_CH];
    logic [INC_BITS-1:0] sum     [NUM_CH];
    t_pulse_cnt          rem_dec [NUM_CH];

    logic advance;
    logic in_ready;

    assign advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign width_eff = (r_pulse_width == '0) ? PULSE_WIDTH_MIN : r_pulse_width;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            rem_dec[c] = (r_rem[c] != '0) ? r_rem[c] - t_pulse_cnt'(1) : '0;
            inc_sat[c] = (r_inc[c] > PHASE_ONE) ? PHASE_ONE : r_inc[c];
            // A zero increment leaves the top bit clear, so no pulse starts.
            sum[c]     = {1'b0, r_phase[c]} + inc_sat[c];
            n_wrap[c]  = sum[c][PHASE_BITS];
            n_phase[c] = sum[c][PHASE_BITS-1:0];
            n_rem[c]   = n_wrap[c] ? width_eff : rem_dec[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width <= PULSE_WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_pulse_width <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_inc[CH_LEFT]  <= i_in.left_increment;
            r_inc[CH_RIGHT] <= i_in.right_increment;
            r_dir[CH_LEFT]  <= i_in.left_direction;
            r_dir[CH_RIGHT] <= i_in.right_direction;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_phase[c] <= '0;
                r_rem[c]   <= '0;
            end
        end else if (advance) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_phase[c] <= n_phase[c];
                r_rem[c]   <= n_rem[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_level[c]   <= (n_rem[c] != '0);
                r_started[c] <= n_wrap[c];
                r_dir_out[c] <= r_dir[c];
            end
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.left_step_level     = r_level[CH_LEFT];
    assign o_res.right_step_level    = r_level[CH_RIGHT];
    assign o_res.left_pulse_started  = r_started[CH_LEFT];
    assign o_res.right_pulse_started = r_started[CH_RIGHT];
    assign o_res.left_direction_out  = r_dir_out[CH_LEFT];
    assign o_res.right_direction_out = r_dir_out[CH_RIGHT];

endmodule

`default_nettype wire

// File: hw/rtl/ddssp_checker.sv
`default_nettype none

module ddssp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_res_valid,
    input wire logic i_res_ready,
    input wire logic i_left_level,
    input wire logic i_right_level,
    input wire logic i_left_started,
    input wire logic i_right_started,
    input wire logic i_left_dir,
    input wire logic i_right_dir
);

    // A stalled result must hold its contents.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
            && $stable({i_left_level, i_right_level, i_left_started,
                        i_right_started, i_left_dir, i_right_dir}))
        else $error("result changed while stalled");

    // A pulse that starts in a tick is high in that same tick.
    a_left_start_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_left_started |-> i_left_level)
        else $error("left pulse started with step line low");

    a_right_start_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_right_started |-> i_right_level)
        else $error("right pulse started with step line low");

    // A result only appears once an item was taken and has passed the input register.
    a_res_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without an accepted item");

endmodule

bind dual_dds_step_pulse_generator ddssp_checker u_ddssp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_left_level    (o_res.left_step_level),
    .i_right_level   (o_res.right_step_level),
    .i_left_started  (o_res.left_pulse_started),
    .i_right_started (o_res.right_pulse_started),
    .i_left_dir      (o_res.left_direction_out),
    .i_right_dir     (o_res.right_direction_out)
);

`default_nettype wire

// File: bench/dual_dds_step_pulse_generator_tb.sv
`timescale 1ns / 100ps

module dual_dds_step_pulse_generator_tb;
    import ddssp_pkg::*;

    localparam int PHASE_BITS = 24;
    localparam logic [PHASE_BITS:0] INC_LSB = (PHASE_BITS+1)'(1);
    localparam logic [PHASE_BITS:0] PHASE_ONE = INC_LSB << PHASE_BITS;
    localparam logic [PHASE_BITS:0] INC_MAX = '1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES = 8;
    localparam int TICKS_PER_PHASE = 175;

    typedef struct packed {
        logic [PHASE_BITS:0] left_increment;
        logic [PHASE_BITS:0] right_increment;
        logic                left_direction;
        logic                right_direction;
    } t_tick;

    typedef struct packed {
        logic left_step_level;
        logic right_step_level;
        logic left_pulse_started;
        logic right_pulse_started;
        logic left_direction_out;
        logic right_direction_out;
    } t_step_levels;

    // Tracks both phase accumulators and pulse counters and predicts the step
    // lines for every accepted tick.
    class step_scoreboard;
        logic [PHASE_BITS-1:0] phase [NUM_CH];
        t_pulse_cnt            remaining [NUM_CH];
        t_pulse_cnt            pulse_width;
        t_step_levels          expected_q [$];
        int                    errors;
        int                    ticks_checked;
        int                    pulses_seen [NUM_CH];

        function new();
            foreach (phase[ch]) begin
                phase[ch] = '0;
                remaining[ch] = '0;
                pulses_seen[ch] = 0;
            end
            pulse_width = PULSE_WIDTH_RESET;
            errors = 0;
            ticks_checked = 0;
        endfunction

        function bit advance_channel(int ch, logic [PHASE_BITS:0] increment);
            logic [PHASE_BITS:0] step;
            logic [PHASE_BITS:0] sum;
            bit                  started;
            started = 1'b0;
            if (remaining[ch] != '0) begin
                remaining[ch] = remaining[ch] - 1'b1;
            end
            step = (increment > PHASE_ONE) ? PHASE_ONE : increment;
            // The phase is below one turn and the step at most one turn, so the
            // top bit of the sum is the wrap.
            sum = {1'b0, phase[ch]} + step;
            if (sum[PHASE_BITS]) begin
                remaining[ch] = (pulse_width == '0) ? PULSE_WIDTH_MIN : pulse_width;
                started = 1'b1;
            end
            phase[ch] = sum[PHASE_BITS-1:0];
            return started;
        endfunction

        function void note_tick(t_tick t);
            t_step_levels exp_levels;
            exp_levels.left_pulse_started  = advance_channel(CH_LEFT, t.left_increment);
            exp_levels.right_pulse_started = advance_channel(CH_RIGHT, t.right_increment);
            exp_levels.left_step_level     = (remaining[CH_LEFT] != '0);
            exp_levels.right_step_level    = (remaining[CH_RIGHT] != '0);
            exp_levels.left_direction_out  = t.left_direction;
            exp_levels.right_direction_out = t.right_direction;
            expected_q.push_back(exp_levels);
        endfunction

        function void compare_bit(string field, logic exp_val, logic act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected %0b, got %0b", field, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(t_step_levels got);
            t_step_levels exp_levels;
            if (expected_q.size() == 0) begin
                $error("result item arrived with no tick outstanding");
                errors++;
                return;
            end
            exp_levels = expected_q.pop_front();
            ticks_checked++;
            if (got.left_pulse_started === 1'b1) pulses_seen[CH_LEFT]++;
            if (got.right_pulse_started === 1'b1) pulses_seen[CH_RIGHT]++;
            compare_bit("left_step_level", exp_levels.left_step_level,
                        got.left_step_level);
            compare_bit("right_step_level", exp_levels.right_step_level,
                        got.right_step_level);
            compare_bit("left_pulse_started", exp_levels.left_pulse_started,
                        got.left_pulse_started);
            compare_bit("right_pulse_started", exp_levels.right_pulse_started,
                        got.right_pulse_started);
            compare_bit("left_direction_out", exp_levels.left_direction_out,
                        got.left_direction_out);
            compare_bit("right_direction_out", exp_levels.right_direction_out,
                        got.right_direction_out);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ddssp_in_if #(.PHASE_BITS(PHASE_BITS)) tick_ch ();
    ddssp_res_if                           step_ch ();
    ddssp_cfg_if                           width_ch ();

    dual_dds_step_pulse_generator #(.PHASE_BITS(PHASE_BITS)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_ch),
        .o_res   (step_ch),
        .i_cfg   (width_ch)
    );

    step_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int widths_written = 0;
    logic [PHASE_BITS:0] speed [NUM_CH];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        step_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Observes all three channels at the clock edge and runs the watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            if (width_ch.valid && width_ch.ready) begin
                sb.pulse_width = width_ch.data;
            end
            if (tick_ch.valid && tick_ch.ready) begin
                sb.note_tick({tick_ch.left_increment, tick_ch.right_increment,
                              tick_ch.left_direction, tick_ch.right_direction});
            end
            if (step_ch.valid && step_ch.ready) begin
                sb.check_result({step_ch.left_step_level, step_ch.right_step_level,
                                 step_ch.left_pulse_started, step_ch.right_pulse_started,
                                 step_ch.left_direction_out, step_ch.right_direction_out});
            end
            if ((tick_ch.valid && tick_ch.ready) || (step_ch.valid && step_ch.ready) ||
                (width_ch.valid && width_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake in %0d cycles, %0d ticks outstanding",
                         idle_cycles, sb.expected_q.size());
                $display("dual_dds_step_pulse_generator_tb: errors");
                $finish;
            end
        end
    end

    // Leaves valid high after acceptance so back-to-back ticks need no bubble.
    task automatic send_tick(t_tick t);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.left_increment  <= t.left_increment;
        tick_ch.right_increment <= t.right_increment;
        tick_ch.left_direction  <= t.left_direction;
        tick_ch.right_direction <= t.right_direction;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
    endtask

    task automatic send_increments(logic [PHASE_BITS:0] left_inc,
                                   logic [PHASE_BITS:0] right_inc,
                                   logic left_dir, logic right_dir);
        send_tick({left_inc, right_inc, left_dir, right_dir});
    endtask

    // Stops sending and waits until every outstanding tick has its result.
    task automatic settle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pulse_width(t_pulse_cnt width);
        width_ch.valid <= 1'b1;
        width_ch.data  <= width;
        @(posedge clk);
        while (!width_ch.ready) @(posedge clk);
        width_ch.valid <= 1'b0;
        widths_written++;
    endtask

    function automatic logic [PHASE_BITS:0] pick_speed();
        case ($urandom_range(9))
            0:       return '0;
            1:       return (PHASE_BITS+1)'($urandom_range(255, 1));
            2:       return (PHASE_BITS+1)'($urandom_range(PHASE_ONE - INC_LSB, 1));
            3:       return (PHASE_BITS+1)'(PHASE_ONE - $urandom_range(4095, 1));
            4:       return PHASE_ONE;
            5:       return (PHASE_BITS+1)'($urandom_range(INC_MAX, PHASE_ONE + INC_LSB));
            6:       return (PHASE_BITS+1)'($urandom());
            default: return (PHASE_BITS+1)'($urandom_range(PHASE_ONE >> 1, PHASE_ONE >> 3));
        endcase
    endfunction

    // Each motor holds its speed for a stretch of ticks, as a real drive would.
    function automatic t_tick random_tick();
        t_tick t;
        foreach (speed[ch]) begin
            if ($urandom_range(7) == 0) speed[ch] = pick_speed();
        end
        t.left_increment  = speed[CH_LEFT];
        t.right_increment = speed[CH_RIGHT];
        t.left_direction  = 1'($urandom_range(1));
        t.right_direction = 1'($urandom_range(1));
        return t;
    endfunction

    initial begin
        int         pass_idx;
        int         n;
        int         pacing;
        t_pulse_cnt widths [NUM_PHASES];

        clk = 1'b0;
        rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.left_increment = '0;
        tick_ch.right_increment = '0;
        tick_ch.left_direction = 1'b0;
        tick_ch.right_direction = 1'b0;
        width_ch.valid = 1'b0;
        width_ch.data = '0;
        speed[CH_LEFT] = PHASE_ONE >> 2;
        speed[CH_RIGHT] = PHASE_ONE >> 3;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pulse width of two: full-turn steps restart a live pulse.
        send_increments('0, '0, 1'b0, 1'b0);
        send_increments(PHASE_ONE, PHASE_ONE, 1'b1, 1'b0);
        send_increments(PHASE_ONE, '0, 1'b0, 1'b1);
        send_increments(INC_MAX, PHASE_ONE + INC_LSB, 1'b1, 1'b1);
        send_increments(PHASE_ONE >> 1, (PHASE_ONE >> 1) - INC_LSB, 1'b0, 1'b0);
        send_increments(PHASE_ONE >> 1, 25'd1, 1'b1, 1'b0);
        send_increments(PHASE_ONE - INC_LSB, PHASE_ONE - INC_LSB, 1'b0, 1'b1);
        send_increments(25'd1, PHASE_ONE - INC_LSB, 1'b1, 1'b1);
        send_increments('0, '0, 1'b0, 1'b0);
        send_increments('0, '0, 1'b1, 1'b1);
        send_increments(25'h0AAAAAA, 25'h1555555, 1'b0, 1'b1);
        settle();

        // A width of zero behaves as one tick.
        write_pulse_width('0);
        send_increments(PHASE_ONE, PHASE_ONE, 1'b1, 1'b0);
        send_increments('0, PHASE_ONE, 1'b0, 1'b1);
        send_increments('0, '0, 1'b0, 1'b0);
        settle();

        write_pulse_width('1);
        send_increments(PHASE_ONE, INC_MAX, 1'b1, 1'b1);
        send_increments(PHASE_ONE, '0, 1'b0, 1'b0);
        send_increments('0, '0, 1'b1, 1'b0);
        send_increments('0, '0, 1'b0, 1'b1);
        settle();

        widths = '{PULSE_WIDTH_MIN, '1, 8'd3, '0, PULSE_WIDTH_RESET, 8'd0, 8'd0, 8'd5};
        widths[5] = t_pulse_cnt'($urandom_range(16, 4));
        widths[6] = t_pulse_cnt'($urandom_range(254, 9));

        for (pass_idx = 0; pass_idx < NUM_PHASES; pass_idx++) begin
            pacing = pass_idx % 4;
            send_idle_pct  = (pacing == 1) ? 50 : (pacing == 3) ? 32 : 0;
            recv_stall_pct = (pacing == 2) ? 50 : (pacing == 3) ? 32 : 0;
            write_pulse_width(widths[pass_idx]);
            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                if (pass_idx == 5 && n == TICKS_PER_PHASE / 2) settle();
                send_tick(random_tick());
            end
            settle();
        end

        $display("Checked %0d ticks over %0d pulse width settings and four pacing modes,",
                 sb.ticks_checked, widths_written);
        $display("with %0d left and %0d right step pulses started.",
                 sb.pulses_seen[CH_LEFT], sb.pulses_seen[CH_RIGHT]);
        if (sb.errors == 0) begin
            $display("dual_dds_step_pulse_generator_tb: clean");
        end else begin
            $display("dual_dds_step_pulse_generator_tb: errors");
        end
        $finish;
    end

endmodule
